// File: src/dsdd_pkg.sv
// ----------------------------------------------------------------------------
// dsdd_pkg
// Shared types, constants and segment tables for the decimal seven-segment
// digit driver.
// ----------------------------------------------------------------------------
package dsdd_pkg;

   localparam int unsigned VALUE_W = 14;

   localparam logic [VALUE_W-1:0] MAX_SHOWN  = 14'd9999;
   localparam logic [VALUE_W-1:0] WEIGHT_THOU = 14'd1000;
   localparam logic [VALUE_W-1:0] WEIGHT_HUND = 14'd100;
   localparam logic [VALUE_W-1:0] WEIGHT_TENS = 14'd10;

   typedef logic [3:0] bcd_type;
   typedef logic [2:0] place_type;
   typedef logic [7:0] pattern_type;

   localparam place_type PLACE_UNITS = 3'd1;
   localparam place_type PLACE_TENS  = 3'd2;
   localparam place_type PLACE_HUND  = 3'd3;
   localparam place_type PLACE_THOU  = 3'd4;

   typedef struct packed {
      bcd_type thou;
      bcd_type hund;
      bcd_type tens;
      bcd_type units;
   } digits_type;

   typedef struct packed {
      bcd_type            digit;
      logic [VALUE_W-1:0] rest;
   } split_type;

   // Pull one decimal digit of the given weight off the top of a value below
   // ten times that weight: nine parallel compares and a select.
   function automatic split_type split_digit(input logic [VALUE_W-1:0] v,
                                             input logic [VALUE_W-1:0] w);
      split_type r;
      r.digit = '0;
      r.rest  = v;
      for (int k = 1; k <= 9; k++) begin
         if (v >= VALUE_W'(w * k)) begin
            r.digit = bcd_type'(k);
            r.rest  = v - VALUE_W'(w * k);
         end
      end
      return r;
   endfunction

   // Segment bits for the first port.
   function automatic pattern_type seg_port_one(input bcd_type d);
      pattern_type p;
      case (d)
         4'd0:    p = 8'h00;
         4'd1:    p = 8'h90;
         4'd2:    p = 8'h40;
         4'd3:    p = 8'h00;
         4'd4:    p = 8'h90;
         4'd5:    p = 8'h20;
         4'd6:    p = 8'h30;
         4'd7:    p = 8'h80;
         4'd8:    p = 8'h00;
         default: p = 8'h00;
      endcase
      return p;
   endfunction

   // Segment bits for the second port.
   function automatic pattern_type seg_port_two(input bcd_type d);
      pattern_type p;
      case (d)
         4'd0:    p = 8'h04;
         4'd1:    p = 8'h07;
         4'd2:    p = 8'h02;
         4'd3:    p = 8'h03;
         4'd4:    p = 8'h79;
         4'd5:    p = 8'h79;
         4'd6:    p = 8'h78;
         4'd7:    p = 8'h07;
         4'd8:    p = 8'h00;
         default: p = 8'h79;
      endcase
      return p;
   endfunction

   // Digit enable mask on the second port.
   function automatic pattern_type place_mask(input place_type pl);
      pattern_type p;
      case (pl)
         PLACE_UNITS: p = 8'hC0;
         PLACE_TENS:  p = 8'hA0;
         PLACE_HUND:  p = 8'h88;
         PLACE_THOU:  p = 8'h90;
         default:     p = 8'hC0;
      endcase
      return p;
   endfunction

endpackage

// File: src/dsdd_digit_pipe.sv
// ----------------------------------------------------------------------------
// dsdd_digit_pipe
// Four-stage pipeline that clamps the value and splits it into thousands,
// hundreds, tens and units: clamp, thousands, hundreds, then tens and units.
// ----------------------------------------------------------------------------
module dsdd_digit_pipe (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_stall,
   input  logic [dsdd_pkg::VALUE_W-1:0] in_value,
   output logic                         out_valid,
   input  logic                         out_stall,
   output dsdd_pkg::digits_type         out_digits
);
   import dsdd_pkg::*;

   logic                 sat_valid_ff;
   logic [VALUE_W-1:0]   sat_value_ff;
   logic                 th_valid_ff;
   bcd_type              th_digit_ff;
   logic [9:0]           th_rest_ff;
   logic                 hu_valid_ff;
   bcd_type              hu_thou_ff;
   bcd_type              hu_hund_ff;
   logic [6:0]           hu_rest_ff;
   logic                 dg_valid_ff;
   digits_type           dg_digits_ff;

   logic                 sat_stall;
   logic                 th_stall;
   logic                 hu_stall;
   logic                 dg_stall;
   logic [VALUE_W-1:0]   sat_value_in;
   split_type            th_split;
   split_type            hu_split;
   split_type            tn_split;

   // Stall chain: a stage holds only while full and its successor holds.
   assign dg_stall  = dg_valid_ff  && out_stall;
   assign hu_stall  = hu_valid_ff  && dg_stall;
   assign th_stall  = th_valid_ff  && hu_stall;
   assign sat_stall = sat_valid_ff && th_stall;
   assign in_stall  = sat_stall;

   // Stage logic.
   always_comb begin
      sat_value_in = (in_value > MAX_SHOWN) ? MAX_SHOWN : in_value;
      th_split     = split_digit(sat_value_ff, WEIGHT_THOU);
      hu_split     = split_digit(VALUE_W'(th_rest_ff), WEIGHT_HUND);
      tn_split     = split_digit(VALUE_W'(hu_rest_ff), WEIGHT_TENS);
   end

   // Clamp stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         sat_valid_ff <= 1'b0;
      end else if (!sat_stall) begin
         sat_valid_ff <= in_valid;
      end
      if (!sat_stall) begin
         sat_value_ff <= sat_value_in;
      end
   end

   // Thousands stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         th_valid_ff <= 1'b0;
      end else if (!th_stall) begin
         th_valid_ff <= sat_valid_ff;
      end
      if (!th_stall) begin
         th_digit_ff <= th_split.digit;
         th_rest_ff  <= th_split.rest[9:0];
      end
   end

   // Hundreds stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         hu_valid_ff <= 1'b0;
      end else if (!hu_stall) begin
         hu_valid_ff <= th_valid_ff;
      end
      if (!hu_stall) begin
         hu_thou_ff <= th_digit_ff;
         hu_hund_ff <= hu_split.digit;
         hu_rest_ff <= hu_split.rest[6:0];
      end
   end

   // Tens and units stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         dg_valid_ff <= 1'b0;
      end else if (!dg_stall) begin
         dg_valid_ff <= hu_valid_ff;
      end
      if (!dg_stall) begin
         dg_digits_ff.thou  <= hu_thou_ff;
         dg_digits_ff.hund  <= hu_hund_ff;
         dg_digits_ff.tens  <= tn_split.digit;
         dg_digits_ff.units <= tn_split.rest[3:0];
      end
   end

   assign out_valid  = dg_valid_ff;
   assign out_digits = dg_digits_ff;

endmodule

// File: src/dsdd_serializer.sv
// ----------------------------------------------------------------------------
// dsdd_serializer
// Holds one split value and sends its shown digits, most significant first,
// one word per cycle when not stalled, port patterns looked up per digit.
// ----------------------------------------------------------------------------
module dsdd_serializer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  dsdd_pkg::digits_type  in_digits,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dsdd_pkg::place_type   rsp_position,
   output dsdd_pkg::pattern_type rsp_port_one_pattern,
   output dsdd_pkg::pattern_type rsp_port_two_pattern,
   output logic                  rsp_last
);
   import dsdd_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   digits_type digits_ff;
   place_type  place_ff;
   place_type  place_in;
   place_type  shown;
   bcd_type    cur_digit;
   logic       is_last;
   logic       done;
   logic       load;

   // Count shown places: leading zeros blank, units always shown.
   always_comb begin
      if (in_digits.thou != 4'd0) begin
         shown = PLACE_THOU;
      end else if (in_digits.hund != 4'd0) begin
         shown = PLACE_HUND;
      end else if (in_digits.tens != 4'd0) begin
         shown = PLACE_TENS;
      end else begin
         shown = PLACE_UNITS;
      end
   end

   // Pick the digit on show.
   always_comb begin
      case (place_ff)
         PLACE_THOU:  cur_digit = digits_ff.thou;
         PLACE_HUND:  cur_digit = digits_ff.hund;
         PLACE_TENS:  cur_digit = digits_ff.tens;
         PLACE_UNITS: cur_digit = digits_ff.units;
         default:     cur_digit = digits_ff.units;
      endcase
   end

   assign is_last  = (place_ff == PLACE_UNITS);
   assign done     = valid_ff && !rsp_stall && is_last;
   assign in_stall = valid_ff && !done;
   assign load     = in_valid && !in_stall;

   // Advance the place, or take the next value as the last word leaves.
   always_comb begin
      valid_in = valid_ff;
      place_in = place_ff;
      if (load) begin
         valid_in = 1'b1;
         place_in = shown;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (valid_ff && !rsp_stall) begin
         place_in = place_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      place_ff <= place_in;
      if (load) begin
         digits_ff <= in_digits;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_position         = place_ff;
   assign rsp_port_one_pattern = seg_port_one(cur_digit);
   assign rsp_port_two_pattern = place_mask(place_ff) | seg_port_two(cur_digit);
   assign rsp_last             = is_last;

endmodule

// File: src/decimal_seven_segment_digit_driver.sv
// ----------------------------------------------------------------------------
// decimal_seven_segment_digit_driver
// Splits a value into four decimal digits and sends one display word per
// shown digit, leading zeros blanked.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one value (0..9999; larger values show as 9999). rsp_ returns
//   one word per shown digit, thousands first, ending with the units digit,
//   which has rsp_last set. Zero shows a single digit.
//   Both channels move a word at an edge where valid is high and stall low.
// Path: the clamp stage loads at the accepting edge, then the thousands,
//   hundreds and tens/units stages, then the output stage presents the
//   first word of the value.
// Throughput: the output stage sends one digit per cycle while rsp_stall is
//   low, one word per shown digit of a value; a new value is taken
//   in the cycle its predecessor's last word leaves, and the split pipeline
//   keeps taking values while the output stage is busy until it fills.
// Reset: synchronous, clears all valid bits; nothing is held across it.
// Stall: rsp_stall freezes the word on show and backs up the pipeline
//   stage by stage; req_stall rises once the first stage is full and held.
// ----------------------------------------------------------------------------
module decimal_seven_segment_digit_driver (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [dsdd_pkg::VALUE_W-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_position,
   output logic [7:0]                   rsp_port_one_pattern,
   output logic [7:0]                   rsp_port_two_pattern,
   output logic                         rsp_last
);
   import dsdd_pkg::*;

   logic       dig_valid;
   logic       dig_stall;
   digits_type dig_digits;

   // Split the value into decimal digits.
   dsdd_digit_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .in_value   (req_value),
      .out_valid  (dig_valid),
      .out_stall  (dig_stall),
      .out_digits (dig_digits)
   );

   // Send the shown digits one word at a time.
   dsdd_serializer u_ser (
      .clock                (clock),
      .reset                (reset),
      .in_valid             (dig_valid),
      .in_stall             (dig_stall),
      .in_digits            (dig_digits),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_position         (rsp_position),
      .rsp_port_one_pattern (rsp_port_one_pattern),
      .rsp_port_two_pattern (rsp_port_two_pattern),
      .rsp_last             (rsp_last)
   );

endmodule

// File: tb/dsdd_digit_checker.sv
// ----------------------------------------------------------------------------
// dsdd_digit_checker
// Watches both channels of the decimal seven-segment digit driver, works out
// the digit words each accepted value must produce and compares every word
// that leaves the block, field by field, in order.
// ----------------------------------------------------------------------------
module dsdd_digit_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [dsdd_pkg::VALUE_W-1:0] req_value,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [2:0]                   rsp_position,
   input  logic [7:0]                   rsp_port_one_pattern,
   input  logic [7:0]                   rsp_port_two_pattern,
   input  logic                         rsp_last,
   output int                           error_count,
   output int                           pending_words,
   output int                           values_taken,
   output int                           words_checked,
   output int                           saturated_values
);
   timeunit 1ns;
   timeprecision 1ps;
   import dsdd_pkg::*;

   typedef struct packed {
      place_type   position;
      pattern_type port_one;
      pattern_type port_two;
      logic        last;
   } digit_word_type;

   // Segment codes per decimal digit, first and second port.
   localparam pattern_type PORT_ONE_SEGS [10] = '{
      8'h00, 8'h90, 8'h40, 8'h00, 8'h90, 8'h20, 8'h30, 8'h80, 8'h00, 8'h00
   };
   localparam pattern_type PORT_TWO_SEGS [10] = '{
      8'h04, 8'h07, 8'h02, 8'h03, 8'h79, 8'h79, 8'h78, 8'h07, 8'h00, 8'h79
   };

   // Digit enable masks on the second port.
   localparam pattern_type ENABLE_UNITS = 8'hC0;
   localparam pattern_type ENABLE_TENS  = 8'hA0;
   localparam pattern_type ENABLE_HUND  = 8'h88;
   localparam pattern_type ENABLE_THOU  = 8'h90;

   digit_word_type awaited_digits [$];
   int             mismatches;
   int             value_total;
   int             word_total;
   int             clamp_total;

   function automatic pattern_type enable_for(input place_type pl);
      pattern_type m;
      case (pl)
         PLACE_TENS: m = ENABLE_TENS;
         PLACE_HUND: m = ENABLE_HUND;
         PLACE_THOU: m = ENABLE_THOU;
         default:    m = ENABLE_UNITS;
      endcase
      return m;
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string field, input int got, input int want);
      if (got != want)
         report_error($sformatf("word %0d %s: got 0x%0h, expected 0x%0h",
                                word_total, field, got, want));
   endtask

   // Split a value into shown digits, most significant first, and queue them.
   task automatic predict_digit_words(input logic [VALUE_W-1:0] raw);
      int             v;
      int             digit_at [1:4];
      place_type      top_place;
      digit_word_type w;
      v = int'(raw);
      if (raw > MAX_SHOWN) begin
         v = int'(MAX_SHOWN);
         clamp_total++;
      end
      digit_at[1] = v % 10;
      digit_at[2] = (v / 10) % 10;
      digit_at[3] = (v / 100) % 10;
      digit_at[4] = (v / 1000) % 10;
      if (v >= int'(WEIGHT_THOU))      top_place = PLACE_THOU;
      else if (v >= int'(WEIGHT_HUND)) top_place = PLACE_HUND;
      else if (v >= int'(WEIGHT_TENS)) top_place = PLACE_TENS;
      else                             top_place = PLACE_UNITS;
      for (int p = int'(top_place); p >= int'(PLACE_UNITS); p--) begin
         w.position = place_type'(p);
         w.port_one = PORT_ONE_SEGS[digit_at[p]];
         w.port_two = enable_for(w.position) | PORT_TWO_SEGS[digit_at[p]];
         w.last     = (w.position == PLACE_UNITS);
         awaited_digits.push_back(w);
      end
   endtask

   initial begin
      mismatches  = 0;
      value_total = 0;
      word_total  = 0;
      clamp_total = 0;
   end

   // Sample both channels at the edge; compare outgoing words, then predict.
   always @(posedge clock) begin
      digit_word_type want;
      if (reset) begin
         awaited_digits.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_digits.size() == 0) begin
               report_error($sformatf("unexpected word: position %0d last %0b",
                                      rsp_position, rsp_last));
            end else begin
               want = awaited_digits.pop_front();
               check_field("position", rsp_position, want.position);
               check_field("port one pattern", rsp_port_one_pattern, want.port_one);
               check_field("port two pattern", rsp_port_two_pattern, want.port_two);
               check_field("last", rsp_last, want.last);
            end
            word_total++;
         end
         if (req_valid && !req_stall) begin
            predict_digit_words(req_value);
            value_total++;
         end
      end
      error_count      <= mismatches;
      pending_words    <= awaited_digits.size();
      values_taken     <= value_total;
      words_checked    <= word_total;
      saturated_values <= clamp_total;
   end

endmodule

// File: tb/decimal_seven_segment_digit_driver_tb.sv
// ----------------------------------------------------------------------------
// decimal_seven_segment_digit_driver_tb
// Drives values into the digit driver with random gaps and output stalls,
// including one long output hold-off that backs the block up, and lets the
// checker compare every digit word against its own prediction.
// ----------------------------------------------------------------------------
module decimal_seven_segment_digit_driver_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dsdd_pkg::*;

   localparam int RANDOM_VALUES = 480;
   localparam int IDLE_LIMIT    = 2000;
   localparam int HOLD_AT_WORD  = 60;
   localparam int LONG_HOLD     = 400;
   localparam int DRAIN_CYCLES  = 20;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [VALUE_W-1:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_position;
   logic [7:0]         rsp_port_one_pattern;
   logic [7:0]         rsp_port_two_pattern;
   logic               rsp_last;

   int error_count;
   int pending_words;
   int values_taken;
   int words_checked;
   int saturated_values;
   int idle_cycles = 0;

   decimal_seven_segment_digit_driver DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_value            (req_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_position         (rsp_position),
      .rsp_port_one_pattern (rsp_port_one_pattern),
      .rsp_port_two_pattern (rsp_port_two_pattern),
      .rsp_last             (rsp_last)
   );

   dsdd_digit_checker checker_i (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_value            (req_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_position         (rsp_position),
      .rsp_port_one_pattern (rsp_port_one_pattern),
      .rsp_port_two_pattern (rsp_port_two_pattern),
      .rsp_last             (rsp_last),
      .error_count          (error_count),
      .pending_words        (pending_words),
      .values_taken         (values_taken),
      .words_checked        (words_checked),
      .saturated_values     (saturated_values)
   );

   always #4 clock = ~clock;

   // Values near the edges of the blanking decisions and the range.
   localparam logic [VALUE_W-1:0] EDGE_VALUES [10] = '{
      14'd0, 14'd9, 14'd10, 14'd99, 14'd100, 14'd999, 14'd1000, 14'd9999,
      14'd10000, 14'd16383
   };

   // Directed values: extremes, blanking boundaries, every digit, over range.
   localparam logic [VALUE_W-1:0] DIRECTED [22] = '{
      14'd0, 14'd1, 14'd9, 14'd10, 14'd11, 14'd99, 14'd100, 14'd101,
      14'd999, 14'd1000, 14'd1001, 14'd1234, 14'd5678, 14'd9090, 14'd8000,
      14'd9998, 14'd9999, 14'd10000, 14'd12345, 14'd8192, 14'd16383, 14'd7
   };

   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] v;
      int                 e;
      case ($urandom_range(0, 7))
         0: v = VALUE_W'($urandom_range(0, 9));
         1: v = VALUE_W'($urandom_range(10, 99));
         2: v = VALUE_W'($urandom_range(100, 999));
         3, 4: v = VALUE_W'($urandom_range(1000, 9999));
         5: v = VALUE_W'($urandom_range(10000, 16383));
         6: begin
            e = $urandom_range(0, 9);
            v = EDGE_VALUES[e] + VALUE_W'($urandom_range(0, 2)) - 14'd1;
         end
         default: v = VALUE_W'($urandom_range(0, 16383));
      endcase
      return v;
   endfunction

   bit send_burst = 1'b0;

   // Offer one value after a random gap; hold it until the block takes it.
   task automatic send_value(input logic [VALUE_W-1:0] v);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (req_stall);
   endtask

   // Receiver: random stall before each word, burst stretches, one long hold.
   initial begin
      int gap;
      int words_taken;
      bit take_burst;
      words_taken = 0;
      take_burst  = 1'b0;
      wait (!reset);
      forever begin
         if (words_taken % 40 == 0)
            take_burst = ($urandom_range(0, 3) == 0);
         gap = take_burst ? 0 : $urandom_range(0, 15);
         if (words_taken == HOLD_AT_WORD)
            gap = LONG_HOLD;
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         words_taken++;
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i])
         send_value(DIRECTED[i]);

      for (int n = 0; n < RANDOM_VALUES; n++) begin
         if (n % 32 == 0)
            send_burst = ($urandom_range(0, 3) == 0);
         send_value(pick_value());
      end
      req_valid <= 1'b0;

      // Drain: let the last prediction land, wait for every predicted word,
      // then allow for the pipeline.
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d values (%0d above range) and %0d digit words.",
               values_taken, saturated_values, words_checked);
      $display("Random gaps and stalls on both sides, bursts, and a %0d-cycle hold-off.",
               LONG_HOLD);
      if (error_count == 0 && pending_words == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
